/* design/convex_hull_vertex_count_core_assert.svh */
// Assertion macros shared by the convex hull core.
`ifndef CONVEX_HULL_VERTEX_COUNT_CORE_ASSERT_SVH
`define CONVEX_HULL_VERTEX_COUNT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CVX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CVX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/cvxhull_pkg.sv */
// Package with shared constants and types of the convex hull core.
package cvxhull_pkg;

  localparam int MaxPointsDef = 4096;
  localparam int CoordBitsDef = 16;

  // Outcome of comparing the two registered products.
  typedef struct packed {
    logic gt;
    logic lt;
  } cmp_t;

endpackage

/* design/cvxhull_xmul.sv */
// Shared product-pair unit: registers a*b and c*d, then compares them.
module cvxhull_xmul #(
  parameter int OP_W = 17
) (
  input  logic                   clk_i,
  input  logic                   load_i,
  input  logic signed [OP_W-1:0] a_i,
  input  logic signed [OP_W-1:0] b_i,
  input  logic signed [OP_W-1:0] c_i,
  input  logic signed [OP_W-1:0] d_i,
  output cvxhull_pkg::cmp_t      cmp_o
);

  logic signed [2*OP_W-1:0] p1_q, p2_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p1_q <= a_i * b_i;
      p2_q <= c_i * d_i;
    end
  end

  assign cmp_o.gt = (p1_q > p2_q);
  assign cmp_o.lt = (p1_q < p2_q);

endmodule

/* design/convex_hull_vertex_count_core.sv */
// Top level of the convex hull vertex counter (Graham scan over point memories).
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  point in  | start, busy        | point_x_i, point_y_i, last_point_i
//  count out | hull_valid_o       | hull_count_o
//
// Points stream in back to back while loading.
// After the last point, busy stays high for the hull run: the pivot search, the
// order setup, the insertion sort (quadratic in n) and the scan with its pops,
// all paced by the registered reads of the point and work memories.
// A set of fewer than two points reports in the next cycle without going busy.
// Reset is asynchronous and active low and clears the controller only.
// The count strobe lasts one cycle; the receiver cannot stall it.
module convex_hull_vertex_count_core #(
  parameter int MAX_POINTS = cvxhull_pkg::MaxPointsDef,
  parameter int COORD_BITS = cvxhull_pkg::CoordBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COORD_BITS-1:0]         point_x_i,
  input  logic signed [COORD_BITS-1:0]         point_y_i,
  input  logic                                 last_point_i,
  output logic                                 hull_valid_o,
  output logic [$clog2(MAX_POINTS+1)-1:0]      hull_count_o
);

  `include "convex_hull_vertex_count_core_assert.svh"

  localparam int CW = COORD_BITS;
  localparam int TW = COORD_BITS + 1;
  localparam int IW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_PIV_ISSUE, S_PIV_USE, S_ORD_INIT,
    S_SO_KEYRD, S_SO_KEYPT, S_SO_KEYSV, S_SO_JRD, S_SO_JPT, S_SO_JMUL,
    S_SO_JCMP, S_SO_INS,
    S_SC_0, S_SC_1, S_SC_2, S_SC_3, S_SC_NRD, S_SC_NPT, S_SC_NLD,
    S_SC_TEST, S_SC_TURN, S_SC_FLD, S_SC_PUSH
  } state_e;

  state_e state_q;

  // Memories: raw points, and a work memory that holds the sorted order and,
  // during the scan, the hull stack of raw points. A stack slot never lies above
  // the order entry being scanned, so it only covers order entries already read.
  logic [2*CW-1:0] pt_mem [MAX_POINTS];
  logic [2*CW-1:0] wk_mem [MAX_POINTS];

  logic [2*CW-1:0] pt_rdata_q, wk_rdata_q;
  logic [IW-1:0]   ord_rdata;

  logic            pt_we, ord_we, stk_we, wk_we;
  logic [IW-1:0]   pt_waddr, pt_raddr, ord_waddr, ord_raddr, stk_waddr, stk_raddr;
  logic [IW-1:0]   wk_waddr, wk_raddr;
  logic [2*CW-1:0] pt_wdata, stk_wdata, wk_wdata;
  logic [IW-1:0]   ord_wdata;

  // Control and working registers.
  logic [NW-1:0]   loaded_q, n_q, top_q;
  logic [IW-1:0]   i_q, j_q, ins_q, piv_q, key_idx_q, jidx_q;
  logic signed [CW-1:0] pivx_q, pivy_q;
  logic signed [TW-1:0] keyx_q, keyy_q, ax_q, ay_q;
  logic [2*CW-1:0] f_q, s_q, c_q;
  logic            hull_valid_q;
  logic [NW-1:0]   hull_count_q;

  logic            accept;
  logic [NW-1:0]   new_n, last_idx, top_m3;
  logic            at_last;
  logic signed [CW-1:0] rd_x, rd_y;
  logic signed [TW-1:0] tr_x, tr_y;
  logic signed [TW-1:0] v1x, v1y, v2x, v2y;
  logic            piv_better, after;
  logic            mul_load;
  logic signed [TW-1:0] op_a, op_b, op_c, op_d;
  cvxhull_pkg::cmp_t cmp;

  assign accept   = start && !busy;
  assign busy     = (state_q != S_IDLE);
  assign new_n    = (loaded_q < NW'(MAX_POINTS)) ? loaded_q + NW'(1) : loaded_q;
  assign last_idx = n_q - NW'(1);
  assign at_last  = (NW'(i_q) == last_idx);
  assign top_m3   = top_q - NW'(3);

  assign rd_x = pt_rdata_q[2*CW-1:CW];
  assign rd_y = pt_rdata_q[CW-1:0];
  assign tr_x = {rd_x[CW-1], rd_x} - {pivx_q[CW-1], pivx_q};
  assign tr_y = {rd_y[CW-1], rd_y} - {pivy_q[CW-1], pivy_q};

  assign piv_better = (i_q == '0) || (rd_y < pivy_q) ||
                      ((rd_y == pivy_q) && (rd_x < pivx_q));

  // Turn vectors from the two stack tops to the candidate point.
  assign v1x = {s_q[2*CW-1], s_q[2*CW-1:CW]} - {f_q[2*CW-1], f_q[2*CW-1:CW]};
  assign v1y = {s_q[CW-1], s_q[CW-1:0]} - {f_q[CW-1], f_q[CW-1:0]};
  assign v2x = {c_q[2*CW-1], c_q[2*CW-1:CW]} - {s_q[2*CW-1], s_q[2*CW-1:CW]};
  assign v2y = {c_q[CW-1], c_q[CW-1:0]} - {s_q[CW-1], s_q[CW-1:0]};

  // The stored point sorts after the key when its angle is larger, or on
  // a tie when it is higher, or at equal height further right.
  assign after = cmp.lt ||
                 (!cmp.gt && ((ay_q > keyy_q) || ((ay_q == keyy_q) && (ax_q > keyx_q))));

  always_comb begin
    mul_load = 1'b0;
    op_a = tr_x;
    op_b = keyy_q;
    op_c = tr_y;
    op_d = keyx_q;
    case (state_q)
      S_SO_JMUL: mul_load = 1'b1;
      S_SC_TEST: begin
        mul_load = (top_q >= NW'(2));
        op_a = v1x;
        op_b = v2y;
        op_c = v2x;
        op_d = v1y;
      end
      default: mul_load = 1'b0;
    endcase
  end

  cvxhull_xmul #(
    .OP_W (TW)
  ) u_xmul (
    .clk_i  (clk_i),
    .load_i (mul_load),
    .a_i    (op_a),
    .b_i    (op_b),
    .c_i    (op_c),
    .d_i    (op_d),
    .cmp_o  (cmp)
  );

  // Memory address and write control.
  always_comb begin
    pt_we     = 1'b0;
    pt_waddr  = loaded_q[IW-1:0];
    pt_wdata  = {point_x_i, point_y_i};
    pt_raddr  = i_q;
    ord_we    = 1'b0;
    ord_waddr = i_q;
    ord_wdata = i_q;
    ord_raddr = i_q;
    stk_we    = 1'b0;
    stk_waddr = top_q[IW-1:0];
    stk_wdata = c_q;
    stk_raddr = top_m3[IW-1:0];
    case (state_q)
      S_IDLE: pt_we = accept && (loaded_q < NW'(MAX_POINTS));
      S_ORD_INIT: begin
        ord_we = 1'b1;
        if (i_q == piv_q) begin
          ord_waddr = '0;
        end else if (i_q < piv_q) begin
          ord_waddr = i_q + IW'(1);
        end else begin
          ord_waddr = i_q;
        end
      end
      S_SO_KEYPT: pt_raddr = ord_rdata;
      S_SO_JRD:   ord_raddr = j_q;
      S_SO_JPT:   pt_raddr = ord_rdata;
      S_SO_JCMP: begin
        ord_we    = after;
        ord_waddr = j_q + IW'(1);
        ord_wdata = jidx_q;
      end
      S_SO_INS: begin
        ord_we    = 1'b1;
        ord_waddr = ins_q;
        ord_wdata = key_idx_q;
      end
      S_SC_0: ord_raddr = '0;
      S_SC_1: begin
        pt_raddr  = ord_rdata;
        ord_raddr = IW'(1);
      end
      S_SC_2: begin
        pt_raddr  = ord_rdata;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = pt_rdata_q;
      end
      S_SC_3: begin
        stk_we    = 1'b1;
        stk_waddr = IW'(1);
        stk_wdata = pt_rdata_q;
      end
      S_SC_NPT:  pt_raddr = ord_rdata;
      S_SC_PUSH: stk_we = 1'b1;
      default:   pt_we = 1'b0;
    endcase
  end

  // Order and stack accesses never fall in the same cycle; the stack is read
  // only in the turn test, and that data is used only when the top entry is popped.
  assign wk_we     = ord_we || stk_we;
  assign wk_waddr  = stk_we ? stk_waddr : ord_waddr;
  assign wk_wdata  = stk_we ? stk_wdata : (2*CW)'(ord_wdata);
  assign wk_raddr  = (state_q == S_SC_TURN) ? stk_raddr : ord_raddr;
  assign ord_rdata = wk_rdata_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rdata_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wk_we) begin
      wk_mem[wk_waddr] <= wk_wdata;
    end
    wk_rdata_q <= wk_mem[wk_raddr];
  end

  // Sequencer: loading, pivot search, order setup, insertion sort, scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      loaded_q     <= '0;
      n_q          <= '0;
      top_q        <= '0;
      i_q          <= '0;
      j_q          <= '0;
      ins_q        <= '0;
      piv_q        <= '0;
      key_idx_q    <= '0;
      jidx_q       <= '0;
      pivx_q       <= '0;
      pivy_q       <= '0;
      keyx_q       <= '0;
      keyy_q       <= '0;
      ax_q         <= '0;
      ay_q         <= '0;
      f_q          <= '0;
      s_q          <= '0;
      c_q          <= '0;
      hull_valid_q <= 1'b0;
      hull_count_q <= '0;
    end else begin
      hull_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (last_point_i) begin
              n_q      <= new_n;
              loaded_q <= '0;
              i_q      <= '0;
              top_q    <= '0;
              if (new_n < NW'(2)) begin
                hull_valid_q <= 1'b1;
                hull_count_q <= new_n;
              end else begin
                state_q <= S_PIV_ISSUE;
              end
            end else begin
              loaded_q <= new_n;
            end
          end
        end
        S_PIV_ISSUE: state_q <= S_PIV_USE;
        S_PIV_USE: begin
          if (piv_better) begin
            piv_q  <= i_q;
            pivx_q <= rd_x;
            pivy_q <= rd_y;
          end
          if (at_last) begin
            i_q     <= '0;
            state_q <= S_ORD_INIT;
          end else begin
            i_q     <= i_q + IW'(1);
            state_q <= S_PIV_ISSUE;
          end
        end
        S_ORD_INIT: begin
          if (at_last) begin
            if (n_q >= NW'(3)) begin
              i_q     <= IW'(2);
              state_q <= S_SO_KEYRD;
            end else begin
              state_q <= S_SC_0;
            end
          end else begin
            i_q <= i_q + IW'(1);
          end
        end
        S_SO_KEYRD: state_q <= S_SO_KEYPT;
        S_SO_KEYPT: begin
          key_idx_q <= ord_rdata;
          j_q       <= i_q - IW'(1);
          state_q   <= S_SO_KEYSV;
        end
        S_SO_KEYSV: begin
          keyx_q  <= tr_x;
          keyy_q  <= tr_y;
          state_q <= S_SO_JRD;
        end
        S_SO_JRD: state_q <= S_SO_JPT;
        S_SO_JPT: begin
          jidx_q  <= ord_rdata;
          state_q <= S_SO_JMUL;
        end
        S_SO_JMUL: begin
          ax_q    <= tr_x;
          ay_q    <= tr_y;
          state_q <= S_SO_JCMP;
        end
        S_SO_JCMP: begin
          if (after) begin
            if (j_q == IW'(1)) begin
              ins_q   <= IW'(1);
              state_q <= S_SO_INS;
            end else begin
              j_q     <= j_q - IW'(1);
              state_q <= S_SO_JRD;
            end
          end else begin
            ins_q   <= j_q + IW'(1);
            state_q <= S_SO_INS;
          end
        end
        S_SO_INS: begin
          if (at_last) begin
            state_q <= S_SC_0;
          end else begin
            i_q     <= i_q + IW'(1);
            state_q <= S_SO_KEYRD;
          end
        end
        S_SC_0: state_q <= S_SC_1;
        S_SC_1: state_q <= S_SC_2;
        S_SC_2: begin
          f_q     <= pt_rdata_q;
          state_q <= S_SC_3;
        end
        S_SC_3: begin
          s_q   <= pt_rdata_q;
          top_q <= NW'(2);
          if (n_q == NW'(2)) begin
            hull_valid_q <= 1'b1;
            hull_count_q <= NW'(2);
            state_q      <= S_IDLE;
          end else begin
            i_q     <= IW'(2);
            state_q <= S_SC_NRD;
          end
        end
        S_SC_NRD: state_q <= S_SC_NPT;
        S_SC_NPT: state_q <= S_SC_NLD;
        S_SC_NLD: begin
          c_q     <= pt_rdata_q;
          state_q <= S_SC_TEST;
        end
        S_SC_TEST: begin
          if (top_q >= NW'(2)) begin
            state_q <= S_SC_TURN;
          end else begin
            state_q <= S_SC_PUSH;
          end
        end
        S_SC_TURN: begin
          if (cmp.gt) begin
            state_q <= S_SC_PUSH;
          end else begin
            // Not a strict left turn: drop the top and refetch the one below.
            top_q <= top_q - NW'(1);
            s_q   <= f_q;
            if (top_q >= NW'(3)) begin
              state_q <= S_SC_FLD;
            end else begin
              state_q <= S_SC_TEST;
            end
          end
        end
        S_SC_FLD: begin
          f_q     <= wk_rdata_q;
          state_q <= S_SC_TEST;
        end
        S_SC_PUSH: begin
          f_q   <= s_q;
          s_q   <= c_q;
          top_q <= top_q + NW'(1);
          if (at_last) begin
            hull_valid_q <= 1'b1;
            hull_count_q <= top_q + NW'(1);
            state_q      <= S_IDLE;
          end else begin
            i_q     <= i_q + IW'(1);
            state_q <= S_SC_NRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign hull_valid_o = hull_valid_q;
  assign hull_count_o = hull_count_q;

  `CVX_ASSERT_SAME(a_strobe_idle, hull_valid_q, state_q == S_IDLE, "count strobe while running")
  `CVX_ASSERT_SAME(a_top_bound, state_q != S_IDLE, top_q <= n_q, "stack deeper than point set")
  `CVX_ASSERT_SAME(a_stack_nonempty, state_q == S_SC_TEST, top_q != '0, "scan stack ran empty")
  `CVX_ASSERT_NEXT(a_last_starts, accept && last_point_i, busy || hull_valid_o,
                   "closing point neither started a run nor reported")

endmodule
